FILE: hw/rtl/pyuv_pkg.sv
// Package for the packed YUV to RGB unpacker: word types, register map and helpers.
// Depends on nothing; used by packed_yuv_unpack_to_rgb.
package pyuv_pkg;

  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam logic        ModeYuv411 = 1'b0;
  localparam logic        ModeYuv422 = 1'b1;
  localparam logic        RegYuvMode = 1'b0;

  localparam logic [16:0] CoefUBlue  = 17'd456;
  localparam logic [16:0] CoefVRed   = 17'd361;
  localparam logic [7:0]  CoefYGreen = 8'd218;
  localparam logic [6:0]  CoefRGreen = 7'd65;
  localparam logic [4:0]  CoefBGreen = 5'd25;

  typedef struct packed {
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
  } in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       group_last;
  } out_t;

  function automatic logic [7:0] clamp_u8(logic signed [10:0] x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'd0;
    end else if (x > 11'sd255) begin
      r = 8'd255;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/packed_yuv_unpack_to_rgb.sv
// Top level of the packed YUV to RGB unpacker: group unpacking, pixel sequencing and
// a four-stage colour pipeline. Depends on pyuv_pkg.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o  in_t  (word0, word1, word2)
//   out      source     out_valid_o / out_stall_i out_t (blue, green, red, group_last)
//   cfg      sink       APB-style write/read     yuv_mode at byte address 0
//
// One pixel leaves per cycle while the output is not stalled; a 4:1:1 group gives four pixels
// and a 4:2:2 group two, as the pixel sequencer steps through the held group.
// A pixel passes from the group register through stages s2, s3, s4 and s5 to the output.
// Reset clears every valid bit, the pixel counter and yuv_mode.
// A stall on the output holds the whole pipeline, and the input is stalled while the
// held group still has pixels to send.
module packed_yuv_unpack_to_rgb
  import pyuv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic mode_q;
  logic adv;
  logic in_acc;

  // Group register and pixel sequencer.
  logic              grp_v_q;
  logic              grp_mode_q;
  logic [1:0]        cnt_q;
  logic [3:0][7:0]   y_q;
  logic signed [7:0] u_q;
  logic signed [7:0] v_q;
  logic [3:0][7:0]   y_d;
  logic [7:0]        u_d;
  logic [7:0]        v_d;
  logic              pix_last;

  // Colour pipeline stages.
  logic               s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic               s2_last_q, s3_last_q, s4_last_q;
  logic [7:0]         s2_y_q, s3_y_q;
  logic signed [16:0] s2_pu_q, s2_pv_q;
  logic [7:0]         s3_b_q, s3_r_q;
  logic [15:0]        s4_py_q;
  logic [14:0]        s4_pr_q;
  logic [12:0]        s4_pb_q;
  logic [7:0]         s4_b_q, s4_r_q;
  out_t               s5_q;

  logic signed [10:0] blue_sum;
  logic signed [10:0] red_sum;
  logic signed [10:0] green_sum;

  assign pready = 1'b1;
  assign prdata = {{(CfgDataW-1){1'b0}}, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeYuv411;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegYuvMode) begin
      mode_q <= pwdata[0];
    end
  end

  assign adv        = !s5_v_q || !out_stall_i;
  assign pix_last   = (grp_mode_q == ModeYuv422) ? (cnt_q == 2'd1) : (cnt_q == 2'd3);
  assign in_stall_o = grp_v_q && !(adv && pix_last);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    if (mode_q == ModeYuv422) begin
      y_d[0] = in_data_i.word0[7:0];
      y_d[1] = in_data_i.word1[7:0];
      y_d[2] = 8'd0;
      y_d[3] = 8'd0;
      u_d    = {~in_data_i.word0[15], in_data_i.word0[14:8]};
      v_d    = {~in_data_i.word1[15], in_data_i.word1[14:8]};
    end else begin
      y_d[0] = {in_data_i.word0[11:5], 1'b0};
      y_d[1] = {in_data_i.word1[15:9], 1'b0};
      y_d[2] = {in_data_i.word1[3:0], in_data_i.word2[15:13], 1'b0};
      y_d[3] = {in_data_i.word2[7:1], 1'b0};
      u_d    = {in_data_i.word0[15:14], in_data_i.word0[3:2], in_data_i.word1[7:6],
                in_data_i.word2[11], 1'b0};
      v_d    = {in_data_i.word0[13:12], in_data_i.word0[1:0], in_data_i.word1[5:4],
                in_data_i.word2[9], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_v_q    <= 1'b0;
      grp_mode_q <= ModeYuv411;
      cnt_q      <= 2'd0;
    end else if (in_acc) begin
      grp_v_q    <= 1'b1;
      grp_mode_q <= mode_q;
      cnt_q      <= 2'd0;
    end else if (adv && grp_v_q) begin
      grp_v_q <= !pix_last;
      cnt_q   <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      y_q <= y_d;
      u_q <= u_d;
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= grp_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  assign blue_sum  = $signed({3'b000, s2_y_q}) + 11'($signed(s2_pu_q[16:8]));
  assign red_sum   = $signed({3'b000, s2_y_q}) + 11'($signed(s2_pv_q[16:8]));
  assign green_sum = $signed({2'b00, s4_py_q[15:7]}) - $signed({3'b000, s4_pr_q[14:7]})
                   - $signed({5'b00000, s4_pb_q[12:7]});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_y_q    <= y_q[cnt_q];
      s2_last_q <= pix_last;
      s2_pu_q   <= 17'($signed(u_q)) * $signed(CoefUBlue);
      s2_pv_q   <= 17'($signed(v_q)) * $signed(CoefVRed);

      s3_y_q    <= s2_y_q;
      s3_last_q <= s2_last_q;
      s3_b_q    <= clamp_u8(blue_sum);
      s3_r_q    <= clamp_u8(red_sum);

      s4_py_q   <= 16'(s3_y_q) * 16'(CoefYGreen);
      s4_pr_q   <= 15'(s3_r_q) * 15'(CoefRGreen);
      s4_pb_q   <= 13'(s3_b_q) * 13'(CoefBGreen);
      s4_b_q    <= s3_b_q;
      s4_r_q    <= s3_r_q;
      s4_last_q <= s3_last_q;

      s5_q.blue       <= s4_b_q;
      s5_q.red        <= s4_r_q;
      s5_q.green      <= clamp_u8(green_sum);
      s5_q.group_last <= s4_last_q;
    end
  end

  assign out_valid_o = s5_v_q;
  assign out_data_o  = s5_q;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for packed_yuv_unpack_to_rgb: it feeds 4:1:1 and 4:2:2 word groups,
// predicts every pixel and checks each one. Depends on pyuv_pkg and the block itself.
module tb_top;
  import pyuv_pkg::*;

  localparam logic [CfgAddrW-1:0] AddrYuvMode   = CfgAddrW'(4 * RegYuvMode);
  localparam logic [CfgAddrW-1:0] AddrBeyondMap = CfgAddrW'(4);
  localparam int unsigned         MaxCycles     = 300000;
  localparam int unsigned         LongHold      = 200;
  localparam int unsigned         GroupsPerRun  = 32;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  in_t         group_q[$];
  out_t        pixel_q[$];
  logic        yuv_mode_q    = ModeYuv411;
  logic        idle_on       = 1'b1;
  logic        long_hold_req = 1'b0;
  int unsigned groups_taken  = 0;
  int unsigned groups_seen   = 0;
  int unsigned pixels_taken  = 0;
  int unsigned pixels_seen   = 0;
  int unsigned send_gap      = 0;
  int unsigned stall_left    = 0;
  int unsigned cycles        = 0;
  int unsigned fail_count    = 0;

  packed_yuv_unpack_to_rgb i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp_byte(int x);
    if (x < 0) begin
      return 0;
    end else if (x > 255) begin
      return 255;
    end
    return x;
  endfunction

  function automatic out_t pixel_colour(logic [7:0] y, logic signed [7:0] u,
                                        logic signed [7:0] v, logic last);
    out_t px;
    int   yi;
    int   b;
    int   r;
    int   g;
    yi = y;
    b = clamp_byte(yi + ((int'(u) * 456) >>> 8));
    r = clamp_byte(yi + ((int'(v) * 361) >>> 8));
    g = clamp_byte(((yi * 218) >>> 7) - ((r * 65) >>> 7) - ((b * 25) >>> 7));
    px.blue       = b[7:0];
    px.green      = g[7:0];
    px.red        = r[7:0];
    px.group_last = last;
    return px;
  endfunction

  task automatic predict_pixels(in_t g);
    logic [15:0]       y[4];
    logic [15:0]       ub;
    logic [15:0]       vb;
    logic signed [7:0] u;
    logic signed [7:0] v;
    if (yuv_mode_q == ModeYuv411) begin
      y[0] = (g.word0 >> 4) & 16'h00FE;
      y[1] = (g.word1 >> 8) & 16'h00FE;
      y[2] = ((g.word1 << 4) & 16'h00F0) | ((g.word2 >> 12) & 16'h000E);
      y[3] = g.word2 & 16'h00FE;
      ub = ((g.word0 >> 8) & 16'h00C0) | ((g.word0 << 2) & 16'h0030)
         | ((g.word1 >> 4) & 16'h000C) | ((g.word2 >> 10) & 16'h0002);
      vb = ((g.word0 >> 6) & 16'h00C0) | ((g.word0 << 4) & 16'h0030)
         | ((g.word1 >> 2) & 16'h000C) | ((g.word2 >> 8) & 16'h0002);
      u = ub[7:0];
      v = vb[7:0];
      for (int k = 0; k < 4; k++) begin
        pixel_q.push_back(pixel_colour(y[k][7:0], u, v, k == 3));
      end
    end else begin
      u = g.word0[15:8] - 8'h80;
      v = g.word1[15:8] - 8'h80;
      pixel_q.push_back(pixel_colour(g.word0[7:0], u, v, 1'b0));
      pixel_q.push_back(pixel_colour(g.word1[7:0], u, v, 1'b1));
    end
  endtask

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  task automatic apb_access(logic wr, logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (wr && addr == AddrYuvMode) begin
      yuv_mode_q = data[0];
    end
    if (!wr && prdata !== CfgDataW'(yuv_mode_q)) begin
      $display("%0t: yuv_mode read mismatch, expected %0h, actual %0h", $time,
               CfgDataW'(yuv_mode_q), prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(logic mode);
    logic [CfgDataW-1:0] data;
    data    = $urandom;
    data[0] = mode;
    apb_access(1'b1, AddrYuvMode, data);
    apb_access(1'b0, AddrYuvMode, '0);
  endtask

  task automatic queue_group(logic [15:0] w0, logic [15:0] w1, logic [15:0] w2);
    in_t g;
    g.word0 = w0;
    g.word1 = w1;
    g.word2 = w2;
    group_q.push_back(g);
  endtask

  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    while (group_q.size() != 0 || in_valid_i || pixel_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Words accepted by the block are predicted here, pixels are checked here.
  always @(posedge clk_i) begin
    out_t exp_px;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_pixels(in_data_i);
      groups_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pixels_taken++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $time, out_data_o);
        fail_count++;
      end else begin
        exp_px = pixel_q.pop_front();
        check_field("blue", exp_px.blue, out_data_o.blue);
        check_field("green", exp_px.green, out_data_o.green);
        check_field("red", exp_px.red, out_data_o.red);
        check_field("group_last", exp_px.group_last, out_data_o.group_last);
      end
    end
  end

  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = in_valid_i;
    if (rst_ni) begin
      if (groups_seen != groups_taken) begin
        groups_seen = groups_taken;
        nxt_valid   = 1'b0;
        send_gap    = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      end
      if (!nxt_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (group_q.size() != 0) begin
          nxt_valid = 1'b1;
          in_data_i <= group_q.pop_front();
        end
      end
    end
    in_valid_i <= nxt_valid;
  end

  always @(negedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left    = LongHold;
    end
    if (pixels_seen != pixels_taken) begin
      pixels_seen = pixels_taken;
      if (stall_left == 0 && idle_on && $urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, 16);
      end
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) begin
      stall_left--;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    apb_access(1'b0, AddrYuvMode, '0);
    queue_group(16'h0000, 16'h0000, 16'h0000);
    queue_group(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_group(16'hFFFF, 16'h0000, 16'h0000);
    queue_group(16'h0000, 16'hFFFF, 16'h0000);
    queue_group(16'h0000, 16'h0000, 16'hFFFF);
    queue_group(16'h5555, 16'hAAAA, 16'h5555);
    queue_group(16'hAAAA, 16'h5555, 16'hAAAA);
    queue_group(16'h4FFC, 16'h00C0, 16'h0800);
    queue_group(16'h8000, 16'h0000, 16'h0000);
    queue_group(16'h1FF3, 16'hFE0C, 16'h02FE);
    drain();

    apb_access(1'b1, AddrBeyondMap, '1);
    apb_access(1'b0, AddrYuvMode, '0);
    queue_group(16'h4FFC, 16'h00C0, 16'h0800);
    drain();
    apb_access(1'b1, AddrYuvMode, 32'hFFFF_FFFF);
    apb_access(1'b0, AddrYuvMode, '0);
    queue_group(16'h0000, 16'h0000, 16'h0000);
    queue_group(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_group(16'h8000, 16'h8000, 16'h1234);
    queue_group(16'h80FF, 16'h80FF, 16'h0000);
    queue_group(16'hFF00, 16'hFF00, 16'h0000);
    queue_group(16'h00FF, 16'h00FF, 16'hFFFF);
    queue_group(16'h7F80, 16'h0140, 16'hABCD);
    drain();
    apb_access(1'b1, AddrYuvMode, 32'hFFFF_FFFE);
    apb_access(1'b0, AddrYuvMode, '0);

    for (int run = 0; run < 6; run++) begin
      idle_on = (run != 3);
      set_mode(run[0]);
      for (int n = 0; n < GroupsPerRun; n++) begin
        queue_group(random_word(), random_word(), random_word());
      end
      if (run == 2) begin
        long_hold_req = 1'b1;
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: packed_yuv_unpack_to_rgb.f
hw/rtl/pyuv_pkg.sv
hw/rtl/packed_yuv_unpack_to_rgb.sv
bench/tb_top.sv
